// ===== sv/avkv_pkg.sv =====
package avkv_pkg;

   localparam int KEYS_DEFAULT = 3;

   // field widths
   localparam int KEY_IDX_W  = 2;
   localparam int READING_W  = 12;
   localparam int STAMP_W    = 32;
   localparam int THRESH_W   = 12;
   localparam int TIME_W     = 16;
   localparam int VEL_W      = 7;

   // csr port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_THRESHOLD    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_THRESHOLD     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_THRESHOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FASTEST_TIME      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOWEST_TIME      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MINIMUM_VELOCITY  = 3'd5;

   localparam logic [THRESH_W-1:0] HIGH_THRESHOLD_RST    = 12'd1600;
   localparam logic [THRESH_W-1:0] LOW_THRESHOLD_RST     = 12'd1200;
   localparam logic [THRESH_W-1:0] RELEASE_THRESHOLD_RST = 12'd1500;
   localparam logic [TIME_W-1:0]   FASTEST_TIME_RST      = 16'd2000;
   localparam logic [TIME_W-1:0]   SLOWEST_TIME_RST      = 16'd12000;
   localparam logic [VEL_W-1:0]    MINIMUM_VELOCITY_RST  = 7'd24;

   // velocity curve math
   localparam int NORM_W      = 20;              // 1e6 fits in 20 bits
   localparam int NUM_W       = NORM_W + TIME_W; // scaled travel time
   localparam int ROOT_W      = 10;              // root of a value below 1e6
   localparam int PROD_W      = VEL_W + ROOT_W;
   localparam int SUB_W       = NORM_W + 1;
   localparam int DIV_STEPS   = NORM_W;
   localparam int ROOT_STEPS  = NORM_W / 2;
   localparam int SCALE_STEPS = VEL_W;
   localparam int CNT_W       = $clog2(DIV_STEPS);

   localparam logic [VEL_W-1:0]  VEL_MAX     = 7'd127;
   localparam logic [NORM_W-1:0] NORM_SCALE  = 20'd1000000;
   localparam logic [ROOT_W-1:0] ROOT_SCALE  = 10'd1000;

   typedef struct packed {
      logic [THRESH_W-1:0] high_threshold;
      logic [THRESH_W-1:0] low_threshold;
      logic [THRESH_W-1:0] release_threshold;
      logic [TIME_W-1:0]   fastest_time;
      logic [TIME_W-1:0]   slowest_time;
      logic [VEL_W-1:0]    minimum_velocity;
   } cfg_type;

   typedef struct packed {
      logic               start;
      logic [STAMP_W-1:0] elapsed;
   } vel_req_type;

   typedef struct packed {
      logic             busy;
      logic [VEL_W-1:0] velocity;
   } vel_sts_type;

endpackage

// ===== sv/avkv_if.sv =====
interface avkv_req_if import avkv_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KEY_IDX_W-1:0] key_index;
   logic [READING_W-1:0] reading;
   logic [STAMP_W-1:0]   timestamp;

   modport source (output valid, output key_index, output reading, output timestamp,
                   input ready);
   modport sink   (input valid, input key_index, input reading, input timestamp,
                   output ready);
endinterface

interface avkv_rsp_if import avkv_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KEY_IDX_W-1:0] event_key;
   logic                 is_release;
   logic [VEL_W-1:0]     velocity;

   modport source (output valid, output event_key, output is_release, output velocity,
                   input ready);
   modport sink   (input valid, input event_key, input is_release, input velocity,
                   output ready);
endinterface

// ===== sv/avkv_sub_unit.sv =====
module avkv_sub_unit import avkv_pkg::*; (
   input  logic [SUB_W-1:0] a,
   input  logic [SUB_W-1:0] b,
   output logic [SUB_W-1:0] diff,
   output logic             ge
);

   logic [SUB_W:0] wide;

   assign wide = {1'b0, a} - {1'b0, b};
   assign diff = wide[SUB_W-1:0];
   assign ge   = ~wide[SUB_W];

endmodule

// ===== sv/avkv_velocity.sv =====
module avkv_velocity import avkv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  vel_req_type vel_req,
   output vel_sts_type vel_sts
);

   typedef enum logic [2:0] {
      V_IDLE, V_CHECK, V_NORM, V_DIVIDE, V_ROOT, V_SCALE, V_SHRINK
   } vstate_type;

   vstate_type          state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [STAMP_W-1:0]  elapsed_ff, elapsed_in;
   logic [TIME_W-1:0]   divisor_ff, divisor_in;
   logic [TIME_W-1:0]   rem_ff, rem_in;
   logic [NORM_W-1:0]   lo_ff, lo_in;
   logic [NORM_W-1:0]   quo_ff, quo_in;
   logic [NORM_W-1:0]   root_ff, root_in;
   logic [NORM_W-1:0]   bit_ff, bit_in;
   logic [VEL_W-1:0]    vel_ff, vel_in;

   logic [SUB_W-1:0]    sub_a, sub_b, sub_diff;
   logic                sub_ge;
   logic [TIME_W:0]     partial;
   logic [NUM_W-1:0]    num;
   logic [VEL_W-1:0]    spread;
   logic [ROOT_W-1:0]   gap;
   logic [PROD_W-1:0]   prod;

   // shared compare/subtract: divide steps, root steps and the /1000 steps
   avkv_sub_unit u_sub (
      .a    (sub_a),
      .b    (sub_b),
      .diff (sub_diff),
      .ge   (sub_ge)
   );

   assign partial = {rem_ff, lo_ff[NORM_W-1]};

   always_comb begin
      if (state_ff == V_ROOT) begin
         sub_a = SUB_W'(quo_ff);
         sub_b = SUB_W'(root_ff) + SUB_W'(bit_ff);
      end else begin
         sub_a = SUB_W'(partial);
         sub_b = SUB_W'(divisor_ff);
      end
   end

   assign num    = {{NORM_W{1'b0}}, rem_ff} * {{TIME_W{1'b0}}, NORM_SCALE};
   assign spread = VEL_MAX - cfg.minimum_velocity;
   assign gap    = ROOT_SCALE - root_ff[ROOT_W-1:0];
   assign prod   = {{ROOT_W{1'b0}}, spread} * {{VEL_W{1'b0}}, gap};

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      elapsed_in = elapsed_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      lo_in      = lo_ff;
      quo_in     = quo_ff;
      root_in    = root_ff;
      bit_in     = bit_ff;
      vel_in     = vel_ff;
      case (state_ff)
         V_IDLE: begin
            if (vel_req.start) begin
               elapsed_in = vel_req.elapsed;
               state_in   = V_CHECK;
            end
         end
         V_CHECK: begin
            if (elapsed_ff <= STAMP_W'(cfg.fastest_time)) begin
               vel_in   = VEL_MAX;
               state_in = V_IDLE;
            end else if (elapsed_ff >= STAMP_W'(cfg.slowest_time)) begin
               vel_in   = cfg.minimum_velocity;
               state_in = V_IDLE;
            end else begin
               // here fastest < elapsed < slowest, so both fit 16 bits
               divisor_in = cfg.slowest_time - cfg.fastest_time;
               rem_in     = elapsed_ff[TIME_W-1:0] - cfg.fastest_time;
               state_in   = V_NORM;
            end
         end
         V_NORM: begin
            rem_in   = num[NUM_W-1:NORM_W];
            lo_in    = num[NORM_W-1:0];
            quo_in   = '0;
            cnt_in   = CNT_W'(DIV_STEPS - 1);
            state_in = V_DIVIDE;
         end
         V_DIVIDE, V_SHRINK: begin
            rem_in = sub_ge ? sub_diff[TIME_W-1:0] : partial[TIME_W-1:0];
            lo_in  = {lo_ff[NORM_W-2:0], 1'b0};
            quo_in = {quo_ff[NORM_W-2:0], sub_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (state_ff == V_DIVIDE) begin
                  root_in  = '0;
                  bit_in   = NORM_W'(1) << (NORM_W - 2);
                  cnt_in   = CNT_W'(ROOT_STEPS - 1);
                  state_in = V_ROOT;
               end else begin
                  vel_in   = cfg.minimum_velocity + quo_in[VEL_W-1:0];
                  state_in = V_IDLE;
               end
            end
         end
         V_ROOT: begin
            if (sub_ge) begin
               quo_in  = sub_diff[NORM_W-1:0];
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = V_SCALE;
         end
         V_SCALE: begin
            // divide (127 - min) * (1000 - root) by 1000, quotient below 128
            rem_in     = TIME_W'(prod[PROD_W-1:VEL_W]);
            lo_in      = {prod[VEL_W-1:0], {(NORM_W - VEL_W){1'b0}}};
            divisor_in = TIME_W'(ROOT_SCALE);
            quo_in     = '0;
            cnt_in     = CNT_W'(SCALE_STEPS - 1);
            state_in   = V_SHRINK;
         end
         default: state_in = V_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= V_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff     <= cnt_in;
      elapsed_ff <= elapsed_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      lo_ff      <= lo_in;
      quo_ff     <= quo_in;
      root_ff    <= root_in;
      bit_ff     <= bit_in;
      vel_ff     <= vel_in;
   end

   assign vel_sts.busy     = (state_ff != V_IDLE);
   assign vel_sts.velocity = vel_ff;

endmodule

// ===== sv/analog_key_velocity_detector.sv =====
// Channel   Dir  Payload                              Handshake
// req_chan  in   key_index, reading, timestamp        valid/ready
// rsp_chan  out  event_key, is_release, velocity      valid/ready
// csr_*     in   csr_index, csr_wdata                 csr_we, no wait
//
// One request at a time. A request that starts no velocity lookup goes from
// S_IDLE through S_EVAL back to S_IDLE; a note-on also waits in S_VEL while
// the velocity unit clamps the travel time or, on the curve, runs the shared
// subtract unit: 20 divide steps, 10 square-root steps, 7 steps of the /1000.
// Reset is synchronous: per-key flags, FSMs, output valid and csr defaults only.
// A finished result sits in the output register; if it is still held when the
// next one is ready, the FSM waits (a note-off also holds back its key update).
module analog_key_velocity_detector import avkv_pkg::*; #(
   parameter int KEYS = KEYS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   avkv_req_if.sink              req_chan,
   avkv_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int KEY_W = (KEYS > 1) ? $clog2(KEYS) : 1;

   typedef enum logic [1:0] {S_IDLE, S_EVAL, S_VEL} state_type;

   state_type            state_ff, state_in;
   cfg_type              cfg_ff;

   // per-key state
   logic [KEYS-1:0]      seen_ff, seen_in;
   logic [KEYS-1:0]      pressed_ff, pressed_in;
   logic [KEYS-1:0]      timing_ff, timing_in;
   logic [STAMP_W-1:0]   start_time_ff [KEYS];
   logic [STAMP_W-1:0]   start_time_in [KEYS];

   // latched request
   logic [KEY_IDX_W-1:0] key_ff, key_in;
   logic [READING_W-1:0] reading_ff, reading_in;
   logic [STAMP_W-1:0]   stamp_ff, stamp_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KEY_IDX_W-1:0] rsp_key_ff, rsp_key_in;
   logic                 rsp_release_ff, rsp_release_in;
   logic [VEL_W-1:0]     rsp_vel_ff, rsp_vel_in;

   logic                 accept;
   logic                 out_free;
   logic                 key_ok;
   logic [KEY_W-1:0]     key_sel;
   vel_req_type          vel_req;
   vel_sts_type          vel_sts;

   avkv_velocity u_velocity (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .vel_req (vel_req),
      .vel_sts (vel_sts)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // indexes of KEYS and above are dropped without touching per-key state
   assign key_ok  = (32'(key_ff) < 32'(KEYS));
   assign key_sel = KEY_W'(key_ff);

   // csr writes; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.high_threshold    <= HIGH_THRESHOLD_RST;
         cfg_ff.low_threshold     <= LOW_THRESHOLD_RST;
         cfg_ff.release_threshold <= RELEASE_THRESHOLD_RST;
         cfg_ff.fastest_time      <= FASTEST_TIME_RST;
         cfg_ff.slowest_time      <= SLOWEST_TIME_RST;
         cfg_ff.minimum_velocity  <= MINIMUM_VELOCITY_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HIGH_THRESHOLD:    cfg_ff.high_threshold    <= csr_wdata[THRESH_W-1:0];
            CSR_LOW_THRESHOLD:     cfg_ff.low_threshold     <= csr_wdata[THRESH_W-1:0];
            CSR_RELEASE_THRESHOLD: cfg_ff.release_threshold <= csr_wdata[THRESH_W-1:0];
            CSR_FASTEST_TIME:      cfg_ff.fastest_time      <= csr_wdata[TIME_W-1:0];
            CSR_SLOWEST_TIME:      cfg_ff.slowest_time      <= csr_wdata[TIME_W-1:0];
            CSR_MINIMUM_VELOCITY:  cfg_ff.minimum_velocity  <= csr_wdata[VEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in        = state_ff;
      seen_in         = seen_ff;
      pressed_in      = pressed_ff;
      timing_in       = timing_ff;
      start_time_in   = start_time_ff;
      key_in          = key_ff;
      reading_in      = reading_ff;
      stamp_in        = stamp_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_key_in      = rsp_key_ff;
      rsp_release_in  = rsp_release_ff;
      rsp_vel_in      = rsp_vel_ff;
      vel_req.start   = 1'b0;
      vel_req.elapsed = stamp_ff - start_time_ff[key_sel];
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in     = req_chan.key_index;
               reading_in = req_chan.reading;
               stamp_in   = req_chan.timestamp;
               state_in   = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = S_IDLE;
            if (key_ok) begin
               if (!seen_ff[key_sel]) begin
                  // first reading only arms the key
                  seen_in[key_sel] = 1'b1;
               end else if (pressed_ff[key_sel]) begin
                  if (reading_ff >= cfg_ff.release_threshold) begin
                     if (out_free) begin
                        pressed_in[key_sel] = 1'b0;
                        rsp_valid_in        = 1'b1;
                        rsp_key_in          = key_ff;
                        rsp_release_in      = 1'b1;
                        rsp_vel_in          = '0;
                     end else begin
                        state_in = S_EVAL;
                     end
                  end
               end else if (timing_ff[key_sel]) begin
                  if (reading_ff < cfg_ff.low_threshold) begin
                     timing_in[key_sel]  = 1'b0;
                     pressed_in[key_sel] = 1'b1;
                     vel_req.start       = 1'b1;
                     state_in            = S_VEL;
                  end else if (reading_ff >= cfg_ff.high_threshold) begin
                     timing_in[key_sel] = 1'b0;   // travel abandoned
                  end
               end else if (reading_ff < cfg_ff.high_threshold) begin
                  timing_in[key_sel]     = 1'b1;
                  start_time_in[key_sel] = stamp_ff;
               end
            end
         end
         S_VEL: begin
            if (!vel_sts.busy && out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_key_in     = key_ff;
               rsp_release_in = 1'b0;
               rsp_vel_in     = vel_sts.velocity;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seen_ff      <= '0;
         pressed_ff   <= '0;
         timing_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         pressed_ff   <= pressed_in;
         timing_ff    <= timing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      start_time_ff  <= start_time_in;
      key_ff         <= key_in;
      reading_ff     <= reading_in;
      stamp_ff       <= stamp_in;
      rsp_key_ff     <= rsp_key_in;
      rsp_release_ff <= rsp_release_in;
      rsp_vel_ff     <= rsp_vel_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.event_key  = rsp_key_ff;
   assign rsp_chan.is_release = rsp_release_ff;
   assign rsp_chan.velocity   = rsp_vel_ff;

`ifndef SYNTHESIS
   // velocity unit is never running while a new request can come in
   a_idle_engine: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !vel_sts.busy)
      else $error("velocity unit busy while ready");

   a_press_or_time: assert property (@(posedge clock) disable iff (reset)
      (pressed_ff & timing_ff) == '0)
      else $error("key both pressed and timing");

   a_armed_first: assert property (@(posedge clock) disable iff (reset)
      ((pressed_ff | timing_ff) & ~seen_ff) == '0)
      else $error("key active before first reading");

   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_EVAL)
      else $error("accepted request not evaluated");

   a_release_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_release_ff |-> rsp_vel_ff == '0)
      else $error("release with nonzero velocity");
`endif

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   import avkv_pkg::*;

   localparam int NKEYS         = KEYS_DEFAULT;
   localparam int SETTLE_CYCLES = 60;       // covers the slowest note-on
   localparam int CYCLE_LIMIT   = 600000;   // several times the slowest clean run
   localparam int LONG_HOLD     = 400;      // receiver back-pressure stretch
   localparam int REPORT_MAX    = 10;

   // One key event as it leaves the block: note-on (velocity) or note-off.
   typedef struct packed {
      logic [KEY_IDX_W-1:0] key;
      logic                 note_off;
      logic [VEL_W-1:0]     vel;
   } key_event_type;

   // Tracks per-key flags and the register file, predicts the key events each
   // accepted request causes and checks them against the output in order.
   class key_event_board;
      cfg_type            regs;
      bit                 seen[NKEYS];
      bit                 pressed[NKEYS];
      bit                 timing[NKEYS];
      logic [STAMP_W-1:0] t_start[NKEYS];
      key_event_type      due_events[$];
      int                 faults;

      function new();
         regs.high_threshold    = HIGH_THRESHOLD_RST;
         regs.low_threshold     = LOW_THRESHOLD_RST;
         regs.release_threshold = RELEASE_THRESHOLD_RST;
         regs.fastest_time      = FASTEST_TIME_RST;
         regs.slowest_time      = SLOWEST_TIME_RST;
         regs.minimum_velocity  = MINIMUM_VELOCITY_RST;
         foreach (t_start[i]) t_start[i] = '0;
         faults = 0;
      endfunction

      function void fault(string msg);
         faults++;
         if (faults <= REPORT_MAX) $display("ERROR: %s", msg);
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_HIGH_THRESHOLD:    regs.high_threshold    = data[THRESH_W-1:0];
            CSR_LOW_THRESHOLD:     regs.low_threshold     = data[THRESH_W-1:0];
            CSR_RELEASE_THRESHOLD: regs.release_threshold = data[THRESH_W-1:0];
            CSR_FASTEST_TIME:      regs.fastest_time      = data[TIME_W-1:0];
            CSR_SLOWEST_TIME:      regs.slowest_time      = data[TIME_W-1:0];
            CSR_MINIMUM_VELOCITY:  regs.minimum_velocity  = data[VEL_W-1:0];
            default: ;
         endcase
      endfunction

      function void track_reading(logic [KEY_IDX_W-1:0] k, logic [READING_W-1:0] rd,
                                  logic [STAMP_W-1:0] ts);
         key_event_type      ev;
         logic [STAMP_W-1:0] travel;
         longint unsigned    span, over, norm, root, probe, vel;
         if (k >= NKEYS) return;
         if (!seen[k]) begin
            seen[k] = 1'b1;
            return;
         end
         if (pressed[k]) begin
            if (rd >= regs.release_threshold) begin
               pressed[k] = 1'b0;
               ev = '{key: k, note_off: 1'b1, vel: '0};
               due_events.push_back(ev);
            end
         end else if (timing[k]) begin
            if (rd < regs.low_threshold) begin
               travel = ts - t_start[k];
               if (travel <= regs.fastest_time) begin
                  vel = 127;
               end else if (travel >= regs.slowest_time) begin
                  vel = regs.minimum_velocity;
               end else begin
                  // scale into 0..1e6, integer square root, map onto min..127
                  span = regs.slowest_time - regs.fastest_time;
                  over = travel - regs.fastest_time;
                  norm = (over * 1000000) / span;
                  root = 0;
                  for (int b = 9; b >= 0; b--) begin
                     probe = root | (64'd1 << b);
                     if (probe * probe <= norm) root = probe;
                  end
                  if (root > 1000) root = 1000;
                  vel = regs.minimum_velocity
                        + ((127 - regs.minimum_velocity) * (1000 - root)) / 1000;
               end
               timing[k]  = 1'b0;
               pressed[k] = 1'b1;
               ev = '{key: k, note_off: 1'b0, vel: vel[VEL_W-1:0]};
               due_events.push_back(ev);
            end else if (rd >= regs.high_threshold) begin
               timing[k] = 1'b0;
            end
         end else if (rd < regs.high_threshold) begin
            timing[k]  = 1'b1;
            t_start[k] = ts;
         end
      endfunction

      function void check_event(logic [KEY_IDX_W-1:0] key, logic note_off,
                                logic [VEL_W-1:0] vel);
         key_event_type want;
         if (due_events.size() == 0) begin
            fault($sformatf("unexpected event key=%0d off=%0b vel=%0d",
                            key, note_off, vel));
            return;
         end
         want = due_events.pop_front();
         if (key !== want.key || note_off !== want.note_off || vel !== want.vel)
            fault($sformatf({"event mismatch: expected key=%0d off=%0b vel=%0d,",
                             " got key=%0d off=%0b vel=%0d"},
                            want.key, want.note_off, want.vel, key, note_off, vel));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   avkv_req_if req_chan ();
   avkv_rsp_if rsp_chan ();

   key_event_board board = new();

   logic [STAMP_W-1:0] now_us;        // running microsecond clock for stimulus
   int                 counted = 0;   // accepted requests for keys in range
   int                 cycles  = 0;
   bit                 steady  = 1'b0;   // no idling on either side while set
   bit                 hold_off_req = 1'b0;

   always #1 clock = ~clock;

   analog_key_velocity_detector #(.KEYS(NKEYS)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Watchdog: a hung handshake or a lost event ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Idle length: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99, 0);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic void tick();
      now_us += $urandom_range(500, 1);
   endfunction

   // Readings around a threshold; the exact edge value comes up often.
   function automatic logic [READING_W-1:0] at_or_above(logic [READING_W-1:0] th);
      if ($urandom_range(3, 0) == 0) return th;
      return READING_W'($urandom_range(4095, th));
   endfunction

   function automatic logic [READING_W-1:0] below_level(logic [READING_W-1:0] th);
      if (th == 0) return '0;
      if ($urandom_range(3, 0) == 0) return th - 1'b1;
      return READING_W'($urandom_range(th - 1, 0));
   endfunction

   // Mid-travel reading: under the high threshold but not yet under the low one.
   function automatic logic [READING_W-1:0] travel_band();
      if (board.regs.low_threshold < board.regs.high_threshold)
         return READING_W'($urandom_range(board.regs.high_threshold - 1,
                                          board.regs.low_threshold));
      return below_level(board.regs.high_threshold);
   endfunction

   // Register write; the model copy is updated at the edge that takes it.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      board.set_reg(idx, data);
   endtask

   task automatic load_settings(input logic [CSR_DATA_W-1:0] high,
                                input logic [CSR_DATA_W-1:0] low,
                                input logic [CSR_DATA_W-1:0] rel,
                                input logic [CSR_DATA_W-1:0] fast,
                                input logic [CSR_DATA_W-1:0] slow,
                                input logic [CSR_DATA_W-1:0] minv);
      write_reg(CSR_HIGH_THRESHOLD,    high);
      write_reg(CSR_LOW_THRESHOLD,     low);
      write_reg(CSR_RELEASE_THRESHOLD, rel);
      write_reg(CSR_FASTEST_TIME,      fast);
      write_reg(CSR_SLOWEST_TIME,      slow);
      write_reg(CSR_MINIMUM_VELOCITY,  minv);
   endtask

   // Offer one request, hold it until the block takes it, then predict.
   // valid stays high when the next request follows with no gap.
   task automatic send_reading(input logic [KEY_IDX_W-1:0] k,
                               input logic [READING_W-1:0] rd,
                               input logic [STAMP_W-1:0] ts);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.key_index <= k;
      req_chan.reading   <= rd;
      req_chan.timestamp <= ts;
      do @(posedge clock); while (!req_chan.ready);
      board.track_reading(k, rd, ts);
      if (k < NKEYS) counted++;
   endtask

   // Drop valid right at the last accept, drain the events and let any
   // silent request still in flight finish before registers change.
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (board.due_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One well-formed stroke with random content: rest, enter travel (with an
   // occasional bounce that cancels timing), bottom out, hold, let go.
   task automatic key_stroke(input logic [KEY_IDX_W-1:0] k);
      logic [STAMP_W-1:0] t0, travel;
      if ($urandom_range(1, 0)) begin
         tick();
         send_reading(k, at_or_above(board.regs.high_threshold), now_us);
      end
      tick();
      send_reading(k, travel_band(), now_us);
      t0 = now_us;
      if ($urandom_range(4, 0) == 0) begin
         tick();
         send_reading(k, at_or_above(board.regs.high_threshold), now_us);
         tick();
         send_reading(k, travel_band(), now_us);
         t0 = now_us;
      end
      repeat ($urandom_range(2, 0)) send_reading(k, travel_band(), t0 + $urandom_range(999, 0));
      // travel time: fast edge, slow edge, the curve, beyond, and wrapped
      case ($urandom_range(9, 0))
         0:          travel = $urandom_range(board.regs.fastest_time, 0);
         1:          travel = board.regs.fastest_time + $urandom_range(1, 0);
         2:          travel = board.regs.slowest_time - $urandom_range(1, 0);
         3, 4, 5, 6: travel = $urandom_range(board.regs.slowest_time, board.regs.fastest_time);
         7:          travel = board.regs.slowest_time + $urandom_range(5000, 0);
         8:          travel = $urandom;
         default:    travel = $urandom_range(65535, 0);
      endcase
      now_us = t0 + travel;
      send_reading(k, below_level(board.regs.low_threshold), now_us);
      repeat ($urandom_range(2, 0)) begin
         tick();
         send_reading(k, below_level(board.regs.release_threshold), now_us);
      end
      if ($urandom_range(5, 0) != 0) begin
         tick();
         send_reading(k, at_or_above(board.regs.release_threshold), now_us);
      end
   endtask

   // Noise: any key including the unused index, extreme or random levels.
   task automatic stray_reading();
      logic [KEY_IDX_W-1:0] k;
      logic [READING_W-1:0] rd;
      logic [STAMP_W-1:0]   ts;
      k = KEY_IDX_W'($urandom_range(3, 0));
      case ($urandom_range(3, 0))
         0:       rd = '0;
         1:       rd = '1;
         default: rd = READING_W'($urandom_range(4095, 0));
      endcase
      if ($urandom_range(3, 0) == 0) begin
         ts = $urandom;
      end else begin
         tick();
         ts = now_us;
      end
      send_reading(k, rd, ts);
   endtask

   task automatic run_random(input int n);
      int goal;
      goal = counted + n;
      while (counted < goal) begin
         if ($urandom_range(9, 0) < 7) key_stroke(KEY_IDX_W'($urandom_range(NKEYS - 1, 0)));
         else stray_reading();
      end
   endtask

   // Receiver: random stalls, a long hold on request, checks every event.
   initial begin : event_sink
      int stall;
      stall = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready)
            board.check_event(rsp_chan.event_key, rsp_chan.is_release, rsp_chan.velocity);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall = LONG_HOLD;
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            stall--;
         end else begin
            rsp_chan.ready <= 1'b1;
            stall = steady ? 0 : pick_gap();
         end
      end
   end

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] h, l;
      req_chan.valid     <= 1'b0;
      req_chan.key_index <= '0;
      req_chan.reading   <= '0;
      req_chan.timestamp <= '0;
      csr_we             <= 1'b0;
      csr_index          <= CSR_HIGH_THRESHOLD;
      csr_wdata          <= '0;
      now_us = $urandom;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset settings: high 1600, low 1200, release 1500,
      // fastest 2000, slowest 12000, minimum 24.
      send_reading(2'd3, 12'd0,    32'd0);            // unused key index: ignored
      send_reading(2'd0, 12'd0,    32'd0);            // first request only arms
      send_reading(2'd1, 12'd4095, 32'hFFFF_FFFF);
      send_reading(2'd2, 12'd1599, 32'd10);
      send_reading(2'd0, 12'd1600, 32'd100);          // at high: stays idle
      send_reading(2'd0, 12'd1599, 32'd1000);         // starts timing
      send_reading(2'd0, 12'd1200, 32'd2000);         // at low: still timing
      send_reading(2'd0, 12'd1199, 32'd3000);         // travel == fastest -> 127
      send_reading(2'd0, 12'd1499, 32'd3100);         // held
      send_reading(2'd0, 12'd1500, 32'd3200);         // note-off at release level
      send_reading(2'd1, 12'd1599, 32'd5000);
      send_reading(2'd1, 12'd1600, 32'd6000);         // back up: timing cancelled
      send_reading(2'd1, 12'd1500, 32'd7000);
      send_reading(2'd1, 12'd0,    32'd19000);        // travel == slowest -> minimum
      send_reading(2'd1, 12'd4095, 32'd19500);
      send_reading(2'd2, 12'd1599, 32'hFFFF_F000);
      send_reading(2'd2, 12'd1199, 32'h0000_0F00);    // travel across the wrap
      send_reading(2'd2, 12'd4095, 32'h0000_1000);
      send_reading(2'd3, 12'd4095, 32'hFFFF_FFFF);    // unused key index again
      send_reading(2'd0, 12'd1000, 32'd20000);
      send_reading(2'd0, 12'd0,    32'd22001);        // just past fastest
      send_reading(2'd0, 12'd2000, 32'd22500);
      send_reading(2'd1, 12'd1300, 32'd30000);
      send_reading(2'd1, 12'd1100, 32'd41999);        // just short of slowest
      send_reading(2'd1, 12'd1500, 32'd42500);

      // Reset settings, with a long receiver hold while strokes keep coming
      // so the output register fills and the request side stalls.
      run_random(30);
      hold_off_req = 1'b1;
      repeat (6) key_stroke(KEY_IDX_W'($urandom_range(NKEYS - 1, 0)));
      run_random(40);
      settle();

      // Widest velocity span, loosest thresholds, minimum zero.
      load_settings(16'd4095, 16'd1, 16'd4095, 16'd0, 16'd65535, 16'd0);
      run_random(70);
      settle();

      // Time registers at the top, minimum 127, release at any level.
      load_settings(16'd2048, 16'd2047, 16'd0, 16'd65535, 16'd65535, 16'd127);
      run_random(80);
      settle();

      // Slowest below fastest.
      load_settings(16'd3000, 16'd1000, 16'd2000, 16'd5000, 16'd1000, 16'd10);
      run_random(70);
      settle();

      // Thresholds out of order, nothing can start timing; no idling here.
      steady = 1'b1;
      load_settings(16'd0, 16'd4095, 16'd4095, 16'd0, 16'd0, 16'd127);
      run_random(40);
      settle();
      steady = 1'b0;

      // Random settings, junk in the upper data bits to be dropped.
      repeat (2) begin
         h = CSR_DATA_W'($urandom_range(4095, 1));
         l = CSR_DATA_W'($urandom_range(h, 0));
         load_settings(CSR_DATA_W'(h | ($urandom_range(15, 0) << THRESH_W)),
                       CSR_DATA_W'(l | ($urandom_range(15, 0) << THRESH_W)),
                       CSR_DATA_W'($urandom_range(65535, 0)),
                       CSR_DATA_W'($urandom_range(20000, 0)),
                       CSR_DATA_W'($urandom_range(65535, 0)),
                       CSR_DATA_W'($urandom_range(65535, 0)));
         run_random(80);
         settle();
      end

      // Narrow curve, back-to-back requests and events.
      steady = 1'b1;
      load_settings(16'd1600, 16'd1200, 16'd1500, 16'd100, 16'd400, 16'd0);
      run_random(80);
      settle();

      if (board.faults == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
